FILE: rtl/core/hsfd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the humidity sensor frame decoder.
package hsfd_pkg;

   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int TEMP_W     = 15;
   localparam int HUM_W      = 14;
   localparam int CODE_W     = 2;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 48;

   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [13:0] HUM_MAX     = 14'd10000;

   localparam int PROD_T_W = 31;
   localparam int PROD_H_W = 30;

   typedef enum logic [CODE_W-1:0] {
      RC_OK         = 2'd0,
      RC_FIRST_BAD  = 2'd1,
      RC_SECOND_BAD = 2'd2
   } result_code_type;

   typedef struct packed {
      logic                 status_mode;
      logic [WORD_W-1:0]    word_t;
      logic [WORD_W-1:0]    word_h;
      result_code_type      code;
   } frame_stage_type;

   typedef struct packed {
      logic                 status_mode;
      logic [PROD_T_W-1:0]  prod_t;
      logic [PROD_H_W-1:0]  prod_h;
      logic [WORD_W-1:0]    word_h;
      result_code_type      code;
   } scale_stage_type;

   function automatic logic [BYTE_W-1:0] crc_feed(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/humidity_sensor_frame_decoder.sv
// Top level of the humidity sensor frame decoder: byte parsing, CRC check and scaling.
//
//   channel  direction  payload (low bit first)                      handshake
//   req      in         tdata: rx_byte; tuser: frame_start           req_tvalid/req_tready
//   rsp      out        tdata: temp_centi, humidity_centi,           rsp_tvalid/rsp_tready
//                              status_word, result_code, pad
//   csr      in         csr_data: frame_mode                         csr_valid/csr_ready
//
// One byte per cycle while req_tready is high. After the byte that closes its frame, a result
// passes the frame register, multiplier register and output register. Stalls on rsp back up
// stage by stage; req_tready drops only when all three stages hold items. Reset is
// synchronous and clears the frame state, the mode register and all stage valid flags.
module humidity_sensor_frame_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hsfd_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] rx_byte
   input  logic [hsfd_pkg::REQ_USER_W-1:0] req_tuser,  // [0] frame_start
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hsfd_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [14:0] temp_centi, [28:15]
                                                       // humidity_centi, [44:29]
                                                       // status_word, [46:45] result_code,
                                                       // [47] zero
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_data    // frame_mode
);
   import hsfd_pkg::*;

   localparam logic [2:0] POS_HI_A = 3'd0;
   localparam logic [2:0] POS_LO_A = 3'd1;
   localparam logic [2:0] POS_CRC_A = 3'd2;
   localparam logic [2:0] POS_HI_B = 3'd3;
   localparam logic [2:0] POS_LO_B = 3'd4;
   localparam logic [2:0] POS_CRC_B = 3'd5;

   logic                  mode_ff;
   logic [2:0]            pos_ff, pos_in;
   logic [BYTE_W-1:0]     crc_ff, crc_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [WORD_W-1:0]     held_ff, held_in;
   logic                  good_ff, good_in;

   logic                  a_v_ff, b_v_ff, o_v_ff;
   frame_stage_type       a_ff, a_in;
   scale_stage_type       b_ff, b_in;
   logic [RSP_DATA_W-1:0] o_ff, o_in;

   logic                  en_a, en_b, en_o, accept, emit;
   logic [BYTE_W-1:0]     rx_byte;
   logic [2:0]            pos;
   logic [BYTE_W-1:0]     crc_base, crc_new;
   logic                  crc_match;

   logic [PROD_T_W:0]     sum_t;
   logic [PROD_H_W:0]     sum_h;
   logic [TEMP_W-1:0]     q_t;
   logic [HUM_W-1:0]      q_h, h_clamped;
   logic [TEMP_W:0]       t_wide;
   logic                  meas_ok;
   logic [TEMP_W-1:0]     temp_out;
   logic [HUM_W-1:0]      hum_out;
   logic [WORD_W-1:0]     status_out;

   assign en_o       = !o_v_ff || rsp_tready;
   assign en_b       = !b_v_ff || en_o;
   assign en_a       = !a_v_ff || en_b;
   assign req_tready = en_a;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = o_ff;
   assign rx_byte    = req_tdata[BYTE_W-1:0];

   always_comb begin
      pos = req_tuser[0] ? POS_HI_A : pos_ff;
      if (pos > POS_CRC_B || (mode_ff && pos > POS_CRC_A)) begin
         pos = POS_HI_A;
      end
      crc_base  = (pos == POS_HI_A || pos == POS_HI_B) ? CRC_INIT : crc_ff;
      crc_new   = crc_feed(crc_base, rx_byte);
      crc_match = (crc_base == rx_byte);

      pos_in  = pos_ff;
      crc_in  = crc_ff;
      word_in = word_ff;
      held_in = held_ff;
      good_in = good_ff;
      emit    = 1'b0;
      a_in    = '{status_mode: mode_ff, word_t: held_ff, word_h: word_ff, code: RC_OK};

      unique case (pos)
         POS_HI_A, POS_HI_B: begin
            crc_in  = crc_new;
            word_in = {rx_byte, {BYTE_W{1'b0}}};
            pos_in  = pos + 3'd1;
         end
         POS_LO_A, POS_LO_B: begin
            crc_in  = crc_new;
            word_in = {word_ff[WORD_W-1:BYTE_W], rx_byte};
            pos_in  = pos + 3'd1;
         end
         POS_CRC_A: begin
            crc_in = CRC_INIT;
            if (mode_ff) begin
               emit        = 1'b1;
               pos_in      = POS_HI_A;
               a_in.word_h = word_ff;
               a_in.code   = crc_match ? RC_OK : RC_FIRST_BAD;
            end else begin
               held_in = word_ff;
               good_in = crc_match;
               pos_in  = POS_HI_B;
            end
         end
         POS_CRC_B: begin
            crc_in      = CRC_INIT;
            emit        = 1'b1;
            pos_in      = POS_HI_A;
            a_in.word_t = held_ff;
            a_in.word_h = word_ff;
            a_in.code   = !good_ff ? RC_FIRST_BAD :
                          (crc_match ? RC_OK : RC_SECOND_BAD);
         end
         default: begin
            pos_in = POS_HI_A;
         end
      endcase
   end

   always_comb begin
      b_in.status_mode = a_ff.status_mode;
      b_in.prod_t      = PROD_T_W'(a_ff.word_t * TEMP_SCALE);
      b_in.prod_h      = PROD_H_W'(a_ff.word_h * HUM_SCALE);
      b_in.word_h      = a_ff.word_h;
      b_in.code        = a_ff.code;
   end

   // divide by 65535: (p + (p >> 16) + 1) >> 16
   always_comb begin
      sum_t      = {1'b0, b_ff.prod_t} + (PROD_T_W+1)'(b_ff.prod_t >> WORD_W)
                   + (PROD_T_W+1)'(1);
      sum_h      = {1'b0, b_ff.prod_h} + (PROD_H_W+1)'(b_ff.prod_h >> WORD_W)
                   + (PROD_H_W+1)'(1);
      q_t        = sum_t[WORD_W +: TEMP_W];
      q_h        = sum_h[WORD_W +: HUM_W];
      h_clamped  = (q_h > HUM_MAX) ? HUM_MAX : q_h;
      t_wide     = {1'b0, q_t} - TEMP_OFFSET;
      meas_ok    = !b_ff.status_mode && (b_ff.code == RC_OK);
      temp_out   = meas_ok ? t_wide[TEMP_W-1:0] : '0;
      hum_out    = meas_ok ? h_clamped : '0;
      status_out = (b_ff.status_mode && b_ff.code == RC_OK) ? b_ff.word_h : '0;
      o_in       = {1'b0, b_ff.code, status_out, hum_out, temp_out};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         pos_ff  <= POS_HI_A;
         crc_ff  <= CRC_INIT;
         word_ff <= '0;
         held_ff <= '0;
         good_ff <= 1'b0;
         a_v_ff  <= 1'b0;
         b_v_ff  <= 1'b0;
         o_v_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         if (accept) begin
            pos_ff  <= pos_in;
            crc_ff  <= crc_in;
            word_ff <= word_in;
            held_ff <= held_in;
            good_ff <= good_in;
         end
         if (en_a) begin
            a_v_ff <= accept && emit;
         end
         if (en_b) begin
            b_v_ff <= a_v_ff;
         end
         if (en_o) begin
            o_v_ff <= b_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_ff <= a_in;
      end
      if (en_b) begin
         b_ff <= b_in;
      end
      if (en_o) begin
         o_ff <= o_in;
      end
   end

endmodule

FILE: rtl/core/hsfd_checker.sv
// Port-level checker for the humidity sensor frame decoder, with its bind.
module hsfd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [hsfd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hsfd_pkg::*;

   logic [TEMP_W-1:0] temp;
   logic [HUM_W-1:0]  hum;
   logic [WORD_W-1:0] status;
   logic [CODE_W-1:0] code;

   assign temp   = rsp_tdata[14:0];
   assign hum    = rsp_tdata[28:15];
   assign status = rsp_tdata[44:29];
   assign code   = rsp_tdata[46:45];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item dropped or changed under stall");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && code != RC_OK |-> temp == '0 && hum == '0 && status == '0)
      else $error("values present on CRC mismatch");

   a_mode_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != '0 |-> temp == '0 && hum == '0 && code == RC_OK)
      else $error("status word mixed with measurement fields");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> hum <= HUM_MAX && code != 2'd3 && rsp_tdata[47] == 1'b0)
      else $error("humidity or code out of range");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/sv/tb_humidity_sensor_frame_decoder.sv
// Self-checking testbench for the humidity sensor frame decoder: random reply bytes, CRC and scaling.
module tb_humidity_sensor_frame_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import hsfd_pkg::*;

   localparam logic MODE_MEASURE = 1'b0;
   localparam logic MODE_STATUS  = 1'b1;
   localparam int   CYCLE_LIMIT  = 400000;
   localparam int   DRAIN_CYCLES = 8;
   localparam int   PHASE_ITEMS  = 150;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              frame_start;
   } reply_byte_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_centi;
      logic [HUM_W-1:0]         humidity_centi;
      logic [WORD_W-1:0]        status_word;
      result_code_type          code;
   } reading_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_data = 1'b0;

   reply_byte_type byte_backlog[$];
   reading_type    pending_readings[$];
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          queued_bytes = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          need_start = 1'b1;

   logic              mode_copy = MODE_MEASURE;
   logic [2:0]        byte_pos = '0;
   logic [BYTE_W-1:0] crc_run = CRC_INIT;
   logic [WORD_W-1:0] word_asm = '0;
   logic [WORD_W-1:0] first_word = '0;
   logic              first_good = 1'b0;

   humidity_sensor_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] r;
      r = crc;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         if (r[BYTE_W-1] ^ data[k]) begin
            r = {r[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[BYTE_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] word_crc(input logic [WORD_W-1:0] w);
      return crc8_next(crc8_next(CRC_INIT, w[15:8]), w[7:0]);
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return WORD_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                                input logic [WORD_W-1:0] want);
      if (mismatch_count < 40) begin
         $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
      end
      mismatch_count++;
   endtask

   task automatic decode_reply_byte(input logic [BYTE_W-1:0] b, input logic start);
      reading_type r;
      logic        good;
      int unsigned t_scaled;
      int unsigned h_scaled;
      r = '0;
      if (start) begin
         byte_pos = '0;
      end
      if (byte_pos >= 3'd6 || (mode_copy == MODE_STATUS && byte_pos >= 3'd3)) begin
         byte_pos = '0;
      end
      if (byte_pos == 3'd0 || byte_pos == 3'd3) begin
         crc_run = CRC_INIT;
      end
      case (byte_pos)
         3'd0, 3'd3: begin
            crc_run = crc8_next(crc_run, b);
            word_asm = {b, 8'h00};
            byte_pos = byte_pos + 3'd1;
         end
         3'd1, 3'd4: begin
            crc_run = crc8_next(crc_run, b);
            word_asm[7:0] = b;
            byte_pos = byte_pos + 3'd1;
         end
         3'd2: begin
            good = (crc_run == b);
            crc_run = CRC_INIT;
            if (mode_copy == MODE_STATUS) begin
               r.status_word = good ? word_asm : '0;
               r.code = good ? RC_OK : RC_FIRST_BAD;
               pending_readings.push_back(r);
               byte_pos = '0;
            end else begin
               first_word = word_asm;
               first_good = good;
               byte_pos = 3'd3;
            end
         end
         default: begin
            good = (crc_run == b);
            byte_pos = '0;
            crc_run = CRC_INIT;
            if (!first_good || !good) begin
               r.code = first_good ? RC_SECOND_BAD : RC_FIRST_BAD;
            end else begin
               t_scaled = (32'd17500 * first_word) / 32'd65535;
               h_scaled = (32'd10000 * word_asm) / 32'd65535;
               if (h_scaled > 10000) begin
                  h_scaled = 10000;
               end
               r.temp_centi = TEMP_W'(int'(t_scaled) - 4500);
               r.humidity_centi = HUM_W'(h_scaled);
               r.code = RC_OK;
            end
            pending_readings.push_back(r);
         end
      endcase
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic start);
      reply_byte_type item;
      item.rx_byte = b;
      item.frame_start = start;
      byte_backlog.push_back(item);
      queued_bytes++;
   endtask

   task automatic push_word(input logic [WORD_W-1:0] w, input bit crc_ok, input logic start);
      logic [BYTE_W-1:0] c;
      c = word_crc(w);
      if (!crc_ok) begin
         c = c ^ BYTE_W'($urandom_range(255, 1));
      end
      push_byte(w[15:8], start);
      push_byte(w[7:0], 1'b0);
      push_byte(c, 1'b0);
   endtask

   task automatic push_frame(input logic status_mode, input bit broken);
      logic [BYTE_W-1:0] bytes[6];
      logic [WORD_W-1:0] w;
      logic              start;
      int                n;
      int                keep;
      n = (status_mode == MODE_STATUS) ? 3 : 6;
      for (int wi = 0; wi < n / 3; wi++) begin
         w = pick_word();
         bytes[3*wi]     = w[15:8];
         bytes[3*wi + 1] = w[7:0];
         bytes[3*wi + 2] = word_crc(w);
         if ($urandom_range(99) < 15) begin
            bytes[3*wi + 2] = bytes[3*wi + 2] ^ BYTE_W'($urandom_range(255, 1));
         end
      end
      keep = broken ? $urandom_range(n - 1, 1) : n;
      start = need_start ? 1'b1 : 1'($urandom_range(1));
      for (int i = 0; i < keep; i++) begin
         push_byte(bytes[i], (i == 0) ? start : 1'b0);
      end
      need_start = broken;
   endtask

   task automatic write_mode(input logic m);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (byte_backlog.size() != 0 || req_tvalid || pending_readings.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      reply_byte_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            item = byte_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.rx_byte;
            req_tuser  <= item.frame_start;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_readings.size() == 0) begin
               flag_mismatch("unexpected reading", rsp_tdata[15:0], '0);
            end else begin
               want = pending_readings.pop_front();
               if (rsp_tdata[14:0] !== want.temp_centi) begin
                  flag_mismatch("temp_centi", {1'b0, rsp_tdata[14:0]},
                                {1'b0, want.temp_centi});
               end
               if (rsp_tdata[28:15] !== want.humidity_centi) begin
                  flag_mismatch("humidity_centi", {2'b00, rsp_tdata[28:15]},
                                {2'b00, want.humidity_centi});
               end
               if (rsp_tdata[44:29] !== want.status_word) begin
                  flag_mismatch("status_word", rsp_tdata[44:29], want.status_word);
               end
               if (rsp_tdata[46:45] !== want.code) begin
                  flag_mismatch("result_code", WORD_W'(rsp_tdata[46:45]),
                                WORD_W'(want.code));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            mode_copy = csr_data;
         end
         if (req_tvalid && req_tready) begin
            decode_reply_byte(req_tdata, req_tuser[0]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic mode_plan[8];
      logic status_mode;
      int   pick;
      mode_plan = '{MODE_MEASURE, MODE_STATUS, MODE_STATUS, MODE_MEASURE,
                    MODE_STATUS, MODE_MEASURE, MODE_MEASURE, MODE_STATUS};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_mode(MODE_MEASURE);
      push_word(16'h0000, 1'b1, 1'b1);
      push_word(16'hFFFF, 1'b1, 1'b0);
      push_word(16'hFFFF, 1'b1, 1'b0);
      push_word(16'h0000, 1'b0, 1'b0);
      push_word(16'h8000, 1'b0, 1'b0);
      push_word(16'h1234, 1'b1, 1'b0);
      wait_drained();

      write_mode(MODE_STATUS);
      push_byte(8'hAA, 1'b1);
      push_byte(8'h55, 1'b0);
      push_word(16'hFFFF, 1'b1, 1'b1);
      push_word(16'h0000, 1'b0, 1'b0);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
            default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
         endcase
         status_mode = mode_plan[ph];
         write_mode(status_mode);
         queued_bytes = 0;
         while (queued_bytes < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
               push_frame(status_mode, 1'b0);
            end else if (pick < 90) begin
               push_frame(status_mode, 1'b1);
            end else begin
               push_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
               need_start = 1'b1;
            end
         end
         // leave up to five stray bytes behind so the next mode change can land mid-frame
         repeat ($urandom_range(5)) push_byte(BYTE_W'($urandom_range(255)), 1'b0);
         need_start = 1'($urandom_range(1));
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: humidity_sensor_frame_decoder.f
rtl/core/hsfd_pkg.sv
rtl/core/humidity_sensor_frame_decoder.sv
rtl/core/hsfd_checker.sv
tb/sv/tb_humidity_sensor_frame_decoder.sv
